### rtl/dcalc_pkg.sv
// Shared types, character codes and helper functions for the decimal calculator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dcalc_pkg;

    // Fixed widths of the result fields and of the decimal mantissa
    localparam int VALUE_WIDTH         = 48;
    localparam int MANT_W              = VALUE_WIDTH - 1;
    localparam int DIG_W               = 3;
    localparam int POW_W               = 24;
    localparam int FRACTION_BITS_DEF   = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 4;

    // ASCII codes seen by the parser
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Operator codes
    localparam logic [1:0] OPC_ADD = 2'd0;
    localparam logic [1:0] OPC_SUB = 2'd1;
    localparam logic [1:0] OPC_DIV = 2'd2;
    localparam logic [1:0] OPC_MUL = 2'd3;

    // Status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_DIV_ZERO = 2'd1;
    localparam logic [1:0] STS_BAD_OP   = 2'd2;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    localparam t_value VAL_MAX = {1'b0, {MANT_W{1'b1}}};
    localparam t_value VAL_MIN = {1'b1, {MANT_W{1'b0}}};

    // Input item: one character of the expression
    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_item;

    // Result item
    typedef struct packed {
        t_value     first_value;
        t_value     second_value;
        t_value     result_value;
        logic [1:0] operator_code;
        logic [1:0] status;
    } t_result;

    // Parsed operands as held by the parser
    typedef struct packed {
        logic              phase;
        logic [7:0]        op_char;
        logic [MANT_W-1:0] mant1;
        logic [DIG_W-1:0]  dig1;
        logic              neg1;
        logic [MANT_W-1:0] mant2;
        logic [DIG_W-1:0]  dig2;
        logic              neg2;
    } t_parse;

    typedef enum logic {
        UOP_DIV,
        UOP_MUL
    } t_unit_op;

    // Request to the shared multiply/divide unit
    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

    // Status and saturated magnitude from the shared unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic              big;
        logic [MANT_W-1:0] mag;
    } t_unit_sts;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV_A,
        ST_WAIT_A,
        ST_CONV_B,
        ST_WAIT_B,
        ST_EVAL,
        ST_WAIT_OP,
        ST_OUT
    } t_state;

    // Power of ten for a fraction digit count
    function automatic logic [POW_W-1:0] pow10(input logic [DIG_W-1:0] n);
        logic [POW_W-1:0] p;
        unique case (n)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

    // Signed value from magnitude and sign, saturated
    function automatic t_value from_mag(input logic [MANT_W-1:0] mag,
                                        input logic neg, input logic big);
        t_value pos;
        t_value res;
        pos = t_value'({1'b0, mag});
        if (big) begin
            res = neg ? VAL_MIN : VAL_MAX;
        end else if (neg) begin
            res = -pos;
        end else begin
            res = pos;
        end
        return res;
    endfunction

    // Unsigned magnitude of a signed value; the most negative value maps to 2^(W-1)
    function automatic logic [VALUE_WIDTH-1:0] mag_of(input t_value v);
        logic [VALUE_WIDTH-1:0] u;
        u = v;
        return u[VALUE_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

    // Clamp a sign-extended sum back to the value range
    function automatic t_value sat_wide(input logic [VALUE_WIDTH:0] s);
        t_value res;
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            res = s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
        end else begin
            res = t_value'(s[VALUE_WIDTH-1:0]);
        end
        return res;
    endfunction

endpackage

### rtl/dcalc_parse.sv
// Character parser: sign, decimal mantissas, fraction digit counts and operator.
// Depends on dcalc_pkg.
`timescale 1ns / 1ps

module dcalc_parse #(
    parameter int MAX_FRACTION_DIGITS = dcalc_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_character,
    input  logic               i_clear,
    output dcalc_pkg::t_parse  o_parse
);
    import dcalc_pkg::*;

    localparam logic [DIG_W-1:0] DIG_LIMIT = DIG_W'(MAX_FRACTION_DIGITS);

    t_parse             r_parse, n_parse;
    logic               r_at_start, n_at_start;
    logic               r_in_frac, n_in_frac;
    logic               is_digit;
    logic [3:0]         digit_val;
    logic [MANT_W-1:0]  cur_mant;
    logic [DIG_W-1:0]   cur_dig;
    logic               skip;
    logic [MANT_W+3:0]  tenfold;
    logic [MANT_W-1:0]  new_mant;
    logic [DIG_W-1:0]   new_dig;

    // Append one digit to the operand being parsed, saturating the mantissa
    always_comb begin
        is_digit  = (i_character >= CH_ZERO) && (i_character <= CH_NINE);
        digit_val = 4'(i_character - CH_ZERO);
        cur_mant  = r_parse.phase ? r_parse.mant2 : r_parse.mant1;
        cur_dig   = r_parse.phase ? r_parse.dig2 : r_parse.dig1;
        skip      = r_in_frac && (cur_dig >= DIG_LIMIT);
        tenfold   = {1'b0, cur_mant, 3'b000} + {3'b000, cur_mant, 1'b0}
                  + {MANT_W'(0), digit_val};
        if (skip) begin
            new_mant = cur_mant;
        end else if (tenfold > {4'b0000, {MANT_W{1'b1}}}) begin
            new_mant = {MANT_W{1'b1}};
        end else begin
            new_mant = tenfold[MANT_W-1:0];
        end
        new_dig = (r_in_frac && !skip) ? cur_dig + 1'b1 : cur_dig;
    end

    // Next parse state for the accepted character
    always_comb begin
        n_parse    = r_parse;
        n_at_start = r_at_start;
        n_in_frac  = r_in_frac;
        if (i_clear) begin
            n_parse    = '0;
            n_at_start = 1'b1;
            n_in_frac  = 1'b0;
        end else if (i_accept) begin
            if (!r_parse.phase) begin
                if (r_at_start && (i_character == CH_MINUS)) begin
                    n_parse.neg1 = 1'b1;
                end else if (is_digit) begin
                    n_parse.mant1 = new_mant;
                    n_parse.dig1  = new_dig;
                end else if (i_character == CH_POINT) begin
                    n_in_frac = 1'b1;
                end else begin
                    n_parse.op_char = i_character;
                    n_parse.phase   = 1'b1;
                    n_in_frac       = 1'b0;
                end
                n_at_start = 1'b0;
            end else begin
                if (is_digit) begin
                    n_parse.mant2 = new_mant;
                    n_parse.dig2  = new_dig;
                end else if (i_character == CH_POINT) begin
                    n_in_frac = 1'b1;
                end else if (i_character == CH_MINUS) begin
                    n_parse.neg2 = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse    <= '0;
            r_at_start <= 1'b1;
            r_in_frac  <= 1'b0;
        end else begin
            r_parse    <= n_parse;
            r_at_start <= n_at_start;
            r_in_frac  <= n_in_frac;
        end
    end

    assign o_parse = r_parse;

endmodule

### rtl/dcalc_iter.sv
// Shared iterative unit: restoring divide (one quotient bit per cycle) and
// shift-add multiply (one multiplier bit per cycle) over one adder. Depends on dcalc_pkg.
`timescale 1ns / 1ps

module dcalc_iter #(
    parameter int FRACTION_BITS = dcalc_pkg::FRACTION_BITS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  dcalc_pkg::t_unit_req                               i_req,
    input  logic [dcalc_pkg::VALUE_WIDTH+FRACTION_BITS-1:0]    i_lo,
    input  logic [dcalc_pkg::VALUE_WIDTH-1:0]                  i_opnd,
    output dcalc_pkg::t_unit_sts                               o_sts
);
    import dcalc_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int NW    = W + FRACTION_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_unit_op         r_op, n_op;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_hi, n_hi;
    logic [NW-1:0]    r_lo, n_lo;
    logic [W-1:0]     r_opnd, n_opnd;

    logic [W+1:0]     add_a, add_b, add_s;
    logic             add_c;
    logic             ge;
    logic [W-1:0]     step_hi;
    logic [NW-1:0]    step_lo;
    logic [2*W-1:0]   prod;

    // One step: trial subtract for divide, conditional add and shift for multiply
    always_comb begin
        if (r_op == UOP_DIV) begin
            add_a = {1'b0, r_hi, r_lo[NW-1]};
            add_b = ~{2'b00, r_opnd};
            add_c = 1'b1;
        end else begin
            add_a = {2'b00, r_hi};
            add_b = r_lo[0] ? {2'b00, r_opnd} : {(W+2){1'b0}};
            add_c = 1'b0;
        end
        add_s = add_a + add_b + {{(W+1){1'b0}}, add_c};
        ge    = !add_s[W+1];
        if (r_op == UOP_DIV) begin
            step_hi = ge ? add_s[W-1:0] : add_a[W-1:0];
            step_lo = {r_lo[NW-2:0], ge};
        end else begin
            step_hi = add_s[W:1];
            step_lo = {{FRACTION_BITS{1'b0}}, add_s[0], r_lo[W-1:1]};
        end
    end

    // Load on start, iterate while busy, flag done after the last step
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_opnd = r_opnd;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = (i_req.op == UOP_DIV) ? CNT_W'(NW) : CNT_W'(W);
            n_hi   = '0;
            n_lo   = i_lo;
            n_opnd = i_opnd;
        end else if (r_busy) begin
            n_hi  = step_hi;
            n_lo  = step_lo;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= UOP_DIV;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_opnd <= n_opnd;
    end

    // Saturated magnitude: quotient for divide, product scaled down for multiply
    always_comb begin
        prod       = {r_hi, r_lo[W-1:0]};
        o_sts.busy = r_busy;
        o_sts.done = r_done;
        if (r_op == UOP_DIV) begin
            o_sts.mag = r_lo[MANT_W-1:0];
            o_sts.big = |r_lo[NW-1:MANT_W];
        end else begin
            o_sts.mag = prod[FRACTION_BITS+MANT_W-1:FRACTION_BITS];
            o_sts.big = |prod[2*W-1:FRACTION_BITS+MANT_W];
        end
    end

endmodule

### rtl/decimal_expression_calculator.sv
// Decimal expression calculator: takes an expression such as -12.5*3.25 one ASCII
// character per item and, on the item marked last, returns both operands and the
// sum, difference, product or quotient as signed fixed point with FRACTION_BITS
// fraction bits, truncated and saturated, plus the operator code and a status.
// The last character of an expression starts a
// sequence on one shared divide/multiply unit that retires one bit per cycle:
// two conversions of the operands to fixed point, then either an add, subtract or
// error result formed directly, or a divide or multiply on the shared unit.
// While a result waits to be taken, the characters of the next
// expression are accepted, up to and including its last one.
// Depends on dcalc_pkg, dcalc_parse and dcalc_iter.
`timescale 1ns / 1ps

module decimal_expression_calculator #(
    parameter int FRACTION_BITS       = dcalc_pkg::FRACTION_BITS_DEF,
    parameter int MAX_FRACTION_DIGITS = dcalc_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dcalc_pkg::t_item   i_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dcalc_pkg::t_result o_result
);
    import dcalc_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int NW = W + FRACTION_BITS;

    t_state        r_state, n_state;
    logic          r_pend, n_pend;
    t_value        r_a, r_b;
    t_result       r_out;

    logic          in_acc, out_acc;
    t_parse        parse;
    t_unit_req     unit_req;
    logic [NW-1:0] unit_lo;
    logic [W-1:0]  unit_opnd;
    t_unit_sts     unit_sts;

    logic          is_add, is_sub, is_div, is_mul, use_unit, op_neg;
    logic          cap_a, cap_b, finish;
    logic [1:0]    op_code, op_status;
    logic [W:0]    sum_ext;
    t_value        direct_res;
    logic [W-1:0]  mag_a, mag_b;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    dcalc_parse #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_character (i_item.character),
        .i_clear     (finish),
        .o_parse     (parse)
    );

    dcalc_iter #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .i_lo    (unit_lo),
        .i_opnd  (unit_opnd),
        .o_sts   (unit_sts)
    );

    // Decode the operator and form add/subtract and error results
    always_comb begin
        is_add     = parse.phase && (parse.op_char == CH_PLUS);
        is_sub     = parse.phase && (parse.op_char == CH_MINUS);
        is_div     = parse.phase && (parse.op_char == CH_SLASH);
        is_mul     = parse.phase && (parse.op_char == CH_STAR);
        mag_a      = mag_of(r_a);
        mag_b      = mag_of(r_b);
        op_neg     = r_a[W-1] ^ r_b[W-1];
        sum_ext    = {r_a[W-1], r_a} + (is_sub ? ~{r_b[W-1], r_b} : {r_b[W-1], r_b})
                   + {{W{1'b0}}, is_sub};
        use_unit   = is_mul || (is_div && (r_b != '0));
        op_status  = STS_OK;
        direct_res = '0;
        if (is_add) begin
            op_code    = OPC_ADD;
            direct_res = sat_wide(sum_ext);
        end else if (is_sub) begin
            op_code    = OPC_SUB;
            direct_res = sat_wide(sum_ext);
        end else if (is_div) begin
            op_code = OPC_DIV;
            if (r_b == '0) begin
                op_status = STS_DIV_ZERO;
            end
        end else if (is_mul) begin
            op_code = OPC_MUL;
        end else begin
            op_code   = OPC_ADD;
            op_status = STS_BAD_OP;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_item.last_char) begin
                    n_state = ST_CONV_A;
                end
            end
            ST_CONV_A: n_state = ST_WAIT_A;
            ST_WAIT_A: begin
                if (unit_sts.done) begin
                    n_state = ST_CONV_B;
                end
            end
            ST_CONV_B: n_state = ST_WAIT_B;
            ST_WAIT_B: begin
                if (unit_sts.done) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: n_state = use_unit ? ST_WAIT_OP : ST_OUT;
            ST_WAIT_OP: begin
                if (unit_sts.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_state = (r_pend || (in_acc && i_item.last_char)) ? ST_CONV_A : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: handshakes, unit requests and capture strobes
    always_comb begin
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        unit_req.start = 1'b0;
        unit_req.op    = UOP_DIV;
        unit_lo        = '0;
        unit_opnd      = '0;
        cap_a          = 1'b0;
        cap_b          = 1'b0;
        finish         = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_CONV_A: begin
                unit_req.start = 1'b1;
                unit_lo        = {1'b0, parse.mant1, {FRACTION_BITS{1'b0}}};
                unit_opnd      = {{(W-POW_W){1'b0}}, pow10(parse.dig1)};
            end
            ST_WAIT_A: cap_a = unit_sts.done;
            ST_CONV_B: begin
                unit_req.start = 1'b1;
                unit_lo        = {1'b0, parse.mant2, {FRACTION_BITS{1'b0}}};
                unit_opnd      = {{(W-POW_W){1'b0}}, pow10(parse.dig2)};
            end
            ST_WAIT_B: cap_b = unit_sts.done;
            ST_EVAL: begin
                unit_req.start = use_unit;
                unit_req.op    = is_div ? UOP_DIV : UOP_MUL;
                unit_lo        = is_div ? {mag_a, {FRACTION_BITS{1'b0}}}
                                        : {{FRACTION_BITS{1'b0}}, mag_a};
                unit_opnd      = mag_b;
                finish         = !use_unit;
            end
            ST_WAIT_OP: finish = unit_sts.done;
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = !r_pend;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // Hold a last character taken while the previous result still waits
    always_comb begin
        n_pend = r_pend;
        if (out_acc) begin
            n_pend = 1'b0;
        end else if (r_state == ST_OUT && in_acc && i_item.last_char) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // Capture converted operands and the finished result
    always_ff @(posedge i_clk) begin
        if (cap_a) begin
            r_a <= from_mag(unit_sts.mag, parse.neg1, unit_sts.big);
        end
        if (cap_b) begin
            r_b <= from_mag(unit_sts.mag, parse.neg2, unit_sts.big);
        end
        if (finish) begin
            r_out.first_value   <= r_a;
            r_out.second_value  <= r_b;
            r_out.result_value  <= use_unit ? from_mag(unit_sts.mag, op_neg, unit_sts.big)
                                            : direct_res;
            r_out.operator_code <= op_code;
            r_out.status        <= op_status;
        end
    end

    assign o_result = r_out;

`ifndef SYNTHESIS
    // The shared unit is never asked to start while it is still iterating
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_req.start |-> !unit_sts.busy)
        else $error("shared unit started while busy");

    // A done pulse only arrives while the sequencer waits for it
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_sts.done |-> (r_state == ST_WAIT_A || r_state == ST_WAIT_B
                           || r_state == ST_WAIT_OP))
        else $error("unit done outside a wait state");

    // Division by zero is reported only with a zero divisor and the divide code
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result.status == STS_DIV_ZERO) |->
            (o_result.second_value == '0 && o_result.operator_code == OPC_DIV))
        else $error("division by zero flagged with nonzero divisor");

    // With nothing pending, taking the result reopens the input
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !r_pend && !(in_acc && i_item.last_char)) |=> o_in_ready)
        else $error("input not ready after result taken");
`endif

endmodule
